FILE: sv/css_token_scanner_assert.svh
// Assertion macros shared by the scanner checker.
`ifndef CSS_TOKEN_SCANNER_ASSERT_SVH
`define CSS_TOKEN_SCANNER_ASSERT_SVH

// cond must hold at every clock edge outside reset
`define CTS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante at one edge implies cons at the next edge
`define CTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/cts_pkg.sv
package cts_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [4:0] K_WS      = 5'd0;
    localparam logic [4:0] K_EOF     = 5'd1;
    localparam logic [4:0] K_STRING  = 5'd2;
    localparam logic [4:0] K_HASH    = 5'd3;
    localparam logic [4:0] K_AT      = 5'd4;
    localparam logic [4:0] K_NUMBER  = 5'd5;
    localparam logic [4:0] K_PERCENT = 5'd6;
    localparam logic [4:0] K_DIM     = 5'd7;
    localparam logic [4:0] K_IDENT   = 5'd8;
    localparam logic [4:0] K_FUNC    = 5'd9;
    localparam logic [4:0] K_PUNCT0  = 5'd10;
    localparam logic [4:0] K_DELIM   = 5'd25;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_HIGH   = 8'h80;

    typedef enum logic [4:0] {
        M_IDLE, M_WS, M_COPEN, M_COMMENT, M_CSTAR, M_STRING, M_HASH, M_AT,
        M_IDENT, M_INT, M_FRAC, M_ESIGN, M_EXP, M_UNIT
    } mode_t;

    typedef enum logic [1:0] {PH_RUN, PH_FLUSH, PH_EOF} phase_t;

    typedef enum logic [1:0] {RES_WAIT, RES_TAKE, RES_AGAIN} res_t;

    // one source byte with its character class
    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        logic       digit;
        logic       space;
        logic       name_start;
        logic       in_name;
        logic [4:0] kind;      // punctuation kind or delim
    } entry_t;

    function automatic logic [4:0] punct_kind(input logic [7:0] b);
        logic [4:0] k;
        unique case (b)
            8'h3A:   k = K_PUNCT0;
            8'h3B:   k = K_PUNCT0 + 5'd1;
            8'h2C:   k = K_PUNCT0 + 5'd2;
            8'h7B:   k = K_PUNCT0 + 5'd3;
            8'h7D:   k = K_PUNCT0 + 5'd4;
            8'h28:   k = K_PUNCT0 + 5'd5;
            8'h29:   k = K_PUNCT0 + 5'd6;
            8'h5B:   k = K_PUNCT0 + 5'd7;
            8'h5D:   k = K_PUNCT0 + 5'd8;
            8'h21:   k = K_PUNCT0 + 5'd9;
            8'h2E:   k = K_PUNCT0 + 5'd10;
            8'h3E:   k = K_PUNCT0 + 5'd11;
            8'h2B:   k = K_PUNCT0 + 5'd12;
            8'h7E:   k = K_PUNCT0 + 5'd13;
            8'h2A:   k = K_PUNCT0 + 5'd14;
            default: k = K_DELIM;
        endcase
        return k;
    endfunction

endpackage

FILE: sv/css_token_scanner.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+--------------------------------------------------
// source   | in_valid / in_stall | src_byte, end_of_source
// tokens   | out_valid/out_stall | token_kind, text_start, text_length,
//          |                     | number_length, delim_byte, last_token
//
// One byte per cycle in steady state, while neither side stalls; a byte that closes a
// token is scanned again, as is a byte that ends an exponent with no sign, and each
// held lookahead byte ('/', '.', '+', '-', 'e') is scanned once the byte after it arrives.
// After the final byte the scanner flushes a pending token, then sends EOF.
// Async active-low reset clears queue and scanner; the source stalls only on a
// full four-entry queue, the scanner only while a token waits in a stalled output.
module css_token_scanner #(
    parameter int OFFSET_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  src_byte,
    input  logic        end_of_source,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  token_kind,
    output logic [15:0] text_start,
    output logic [15:0] text_length,
    output logic [15:0] number_length,
    output logic [7:0]  delim_byte,
    output logic        last_token
);

    // front: classify each request and push it into the queue
    logic            push;
    logic            fifo_full;
    cts_pkg::entry_t push_data;

    // queue to the scan step unit
    logic            head_valid;
    logic            pop;
    cts_pkg::entry_t head_data;

    cts_front u_front (
        .in_valid      (in_valid),
        .src_byte      (src_byte),
        .end_of_source (end_of_source),
        .fifo_full     (fifo_full),
        .in_stall      (in_stall),
        .push          (push),
        .push_data     (push_data)
    );

    cts_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .full       (fifo_full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // back: mode machine with two bytes of lookahead; one decision per cycle when not stalled
    cts_back #(
        .OB (OFFSET_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (head_valid),
        .q_data        (head_data),
        .q_pop         (pop),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .token_kind    (token_kind),
        .text_start    (text_start),
        .text_length   (text_length),
        .number_length (number_length),
        .delim_byte    (delim_byte),
        .last_token    (last_token)
    );

endmodule

FILE: sv/cts_front.sv
module cts_front (
    input  logic                  in_valid,
    input  logic [7:0]            src_byte,
    input  logic                  end_of_source,
    input  logic                  fifo_full,
    output logic                  in_stall,
    output logic                  push,
    output cts_pkg::entry_t       push_data
);

    logic alpha;

    assign alpha = (src_byte >= 8'h61 && src_byte <= 8'h7A) ||
                   (src_byte >= 8'h41 && src_byte <= 8'h5A);

    always_comb
    begin
        push_data.data       = src_byte;
        push_data.eos        = end_of_source;
        push_data.digit      = (src_byte >= 8'h30) && (src_byte <= 8'h39);
        push_data.space      = (src_byte == 8'h20) || (src_byte == 8'h09) ||
                               (src_byte == 8'h0D) || (src_byte == 8'h0A) ||
                               (src_byte == 8'h0C);
        push_data.name_start = alpha || (src_byte == 8'h5F) ||
                               (src_byte == cts_pkg::CH_MINUS) ||
                               ((src_byte & cts_pkg::CH_HIGH) != 8'h00);
        push_data.in_name    = push_data.name_start || push_data.digit;
        push_data.kind       = cts_pkg::punct_kind(src_byte);
    end

    assign in_stall = fifo_full;
    assign push     = in_valid && !fifo_full;

endmodule

FILE: sv/cts_fifo.sv
module cts_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cts_pkg::entry_t  push_data,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output cts_pkg::entry_t  head_data
);

    localparam int PW = $clog2(cts_pkg::FIFO_DEPTH);

    cts_pkg::entry_t mem_reg [cts_pkg::FIFO_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;
    logic [PW:0]     count_next;

    assign full       = (count_reg == (PW+1)'(cts_pkg::FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

FILE: sv/cts_back.sv
module cts_back #(
    parameter int OB = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  cts_pkg::entry_t  q_data,
    output logic             q_pop,
    input  logic             out_stall,
    output logic             out_valid,
    output logic [4:0]       token_kind,
    output logic [15:0]      text_start,
    output logic [15:0]      text_length,
    output logic [15:0]      number_length,
    output logic [7:0]       delim_byte,
    output logic             last_token
);

    localparam logic [OB-1:0] POS_MAX = {OB{1'b1}};

    function automatic logic [15:0] sat16(input logic [OB-1:0] v);
        logic [OB+15:0] x;
        x = {16'd0, v};
        return (x > (OB+16)'(17'h0FFFF)) ? 16'hFFFF : x[15:0];
    endfunction

    cts_pkg::phase_t phase_reg, phase_next;
    cts_pkg::mode_t  mode_reg, mode_next;
    logic [OB-1:0]   pos_reg, ts_reg, nl_reg, ts_next, nl_next;
    logic [7:0]      quote_reg, quote_next;
    logic            esc_reg, esc_next;
    cts_pkg::entry_t la_reg [3];
    logic [1:0]      wn_reg;
    logic            need_reg;
    logic            end_reg;

    cts_pkg::entry_t w [3];
    cts_pkg::entry_t c;
    logic [1:0]      wn_eff, wn_next;
    logic            at_end, win_ok;
    logic            a_known, b_known, a_wait, b_wait;
    logic [OB-1:0]   npos, span, pspan;

    cts_pkg::res_t   r;
    logic            em, do_suffix, exp_ok, exp_wait, num_yes, num_wait;
    logic [4:0]      e_kind;
    logic [OB-1:0]   e_start, e_len, e_nl;
    logic [7:0]      e_del;

    logic            fl_em;
    logic [4:0]      fl_kind;
    logic [OB-1:0]   fl_nl;

    logic            out_free, step_go, done, flush_go;
    logic            load;
    logic [4:0]      ld_kind;
    logic [OB-1:0]   ld_start, ld_len, ld_nl;
    logic [7:0]      ld_del;
    logic            ld_last;

    logic            out_valid_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign npos     = (pos_reg < POS_MAX) ? pos_reg + 1'b1 : pos_reg;
    assign span     = (pos_reg >= ts_reg) ? pos_reg - ts_reg : '0;
    assign pspan    = (npos >= ts_reg) ? npos - ts_reg : '0;

    // window: held lookahead plus the queue head when a new byte is due
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            w[i] = la_reg[i];
        wn_eff = wn_reg;
        at_end = end_reg;
        win_ok = 1'b1;
        if (need_reg)
        begin
            if (wn_reg != 2'd3)
                w[wn_reg] = q_data;
            wn_eff = wn_reg + 2'd1;
            at_end = q_data.eos;
            win_ok = q_valid;
        end
    end

    assign c       = w[0];
    assign a_known = (wn_eff > 2'd1);
    assign b_known = (wn_eff > 2'd2);
    assign a_wait  = !a_known && !at_end;
    assign b_wait  = !b_known && !at_end;

    // exponent check for 'e' after digits
    always_comb
    begin
        exp_ok   = 1'b0;
        exp_wait = 1'b0;
        if (a_wait)
            exp_wait = 1'b1;
        else if (a_known && w[1].digit)
            exp_ok = 1'b1;
        else if (a_known && (w[1].data == cts_pkg::CH_PLUS ||
                             w[1].data == cts_pkg::CH_MINUS))
        begin
            if (b_wait)
                exp_wait = 1'b1;
            else
                exp_ok = b_known && w[2].digit;
        end
    end

    // number start check in idle
    always_comb
    begin
        num_yes  = 1'b0;
        num_wait = 1'b0;
        if (c.digit)
            num_yes = 1'b1;
        else if (c.data == cts_pkg::CH_DOT)
        begin
            num_wait = a_wait;
            num_yes  = a_known && w[1].digit;
        end
        else if (c.data == cts_pkg::CH_PLUS || c.data == cts_pkg::CH_MINUS)
        begin
            if (a_wait)
                num_wait = 1'b1;
            else if (a_known && w[1].digit)
                num_yes = 1'b1;
            else if (a_known && w[1].data == cts_pkg::CH_DOT)
            begin
                num_wait = b_wait;
                num_yes  = b_known && w[2].digit;
            end
        end
    end

    // one scan step on the window head
    always_comb
    begin
        r          = cts_pkg::RES_TAKE;
        em         = 1'b0;
        do_suffix  = 1'b0;
        e_kind     = cts_pkg::K_DELIM;
        e_start    = ts_reg;
        e_len      = span;
        e_nl       = '0;
        e_del      = 8'd0;
        mode_next  = mode_reg;
        ts_next    = ts_reg;
        nl_next    = nl_reg;
        quote_next = quote_reg;
        esc_next   = esc_reg;
        unique case (mode_reg)
            cts_pkg::M_WS:
            begin
                if (c.space)
                    r = cts_pkg::RES_TAKE;
                else if (c.data == cts_pkg::CH_SLASH && a_wait)
                    r = cts_pkg::RES_WAIT;
                else if (c.data == cts_pkg::CH_SLASH && a_known &&
                         w[1].data == cts_pkg::CH_STAR)
                    mode_next = cts_pkg::M_COPEN;
                else
                begin
                    em        = 1'b1;
                    e_kind    = cts_pkg::K_WS;
                    mode_next = cts_pkg::M_IDLE;
                    r         = cts_pkg::RES_AGAIN;
                end
            end
            cts_pkg::M_COPEN:
                mode_next = cts_pkg::M_COMMENT;
            cts_pkg::M_COMMENT:
            begin
                if (c.data == cts_pkg::CH_STAR)
                    mode_next = cts_pkg::M_CSTAR;
            end
            cts_pkg::M_CSTAR:
            begin
                if (c.data == cts_pkg::CH_SLASH)
                    mode_next = cts_pkg::M_WS;
                else if (c.data != cts_pkg::CH_STAR)
                    mode_next = cts_pkg::M_COMMENT;
            end
            cts_pkg::M_STRING:
            begin
                if (esc_reg)
                    esc_next = 1'b0;
                else if (c.data == cts_pkg::CH_BSLASH)
                    esc_next = 1'b1;
                else if (c.data == quote_reg)
                begin
                    em        = 1'b1;
                    e_kind    = cts_pkg::K_STRING;
                    mode_next = cts_pkg::M_IDLE;
                end
            end
            cts_pkg::M_HASH, cts_pkg::M_AT, cts_pkg::M_IDENT:
            begin
                if (c.in_name)
                    r = cts_pkg::RES_TAKE;
                else if (mode_reg == cts_pkg::M_IDENT && c.data == cts_pkg::CH_LPAREN)
                begin
                    em        = 1'b1;
                    e_kind    = cts_pkg::K_FUNC;
                    mode_next = cts_pkg::M_IDLE;
                end
                else
                begin
                    em        = 1'b1;
                    e_kind    = (mode_reg == cts_pkg::M_HASH) ? cts_pkg::K_HASH :
                                (mode_reg == cts_pkg::M_AT)   ? cts_pkg::K_AT :
                                                                cts_pkg::K_IDENT;
                    mode_next = cts_pkg::M_IDLE;
                    r         = cts_pkg::RES_AGAIN;
                end
            end
            cts_pkg::M_INT, cts_pkg::M_FRAC:
            begin
                if (c.digit)
                    r = cts_pkg::RES_TAKE;
                else if (mode_reg == cts_pkg::M_INT && c.data == cts_pkg::CH_DOT)
                    mode_next = cts_pkg::M_FRAC;
                else if ((c.data == cts_pkg::CH_LO_E || c.data == cts_pkg::CH_UP_E) &&
                         exp_wait)
                    r = cts_pkg::RES_WAIT;
                else if ((c.data == cts_pkg::CH_LO_E || c.data == cts_pkg::CH_UP_E) &&
                         exp_ok)
                    mode_next = cts_pkg::M_ESIGN;
                else
                    do_suffix = 1'b1;
            end
            cts_pkg::M_ESIGN:
            begin
                mode_next = cts_pkg::M_EXP;
                if (c.data != cts_pkg::CH_PLUS && c.data != cts_pkg::CH_MINUS)
                    r = cts_pkg::RES_AGAIN;
            end
            cts_pkg::M_EXP:
            begin
                if (!c.digit)
                    do_suffix = 1'b1;
            end
            cts_pkg::M_UNIT:
            begin
                if (!c.in_name)
                begin
                    em        = 1'b1;
                    e_kind    = cts_pkg::K_DIM;
                    e_nl      = nl_reg;
                    mode_next = cts_pkg::M_IDLE;
                    r         = cts_pkg::RES_AGAIN;
                end
            end
            default:
            begin
                // between tokens
                mode_next = cts_pkg::M_IDLE;
                if (c.space)
                begin
                    ts_next   = pos_reg;
                    mode_next = cts_pkg::M_WS;
                end
                else if (c.data == cts_pkg::CH_SLASH)
                begin
                    if (a_wait)
                        r = cts_pkg::RES_WAIT;
                    else if (a_known && w[1].data == cts_pkg::CH_STAR)
                    begin
                        ts_next   = pos_reg;
                        mode_next = cts_pkg::M_COPEN;
                    end
                    else
                    begin
                        em      = 1'b1;
                        e_kind  = cts_pkg::K_DELIM;
                        e_start = pos_reg;
                        e_len   = OB'(1);
                        e_del   = c.data;
                    end
                end
                else if (c.data == cts_pkg::CH_DQUOTE || c.data == cts_pkg::CH_SQUOTE)
                begin
                    quote_next = c.data;
                    esc_next   = 1'b0;
                    ts_next    = npos;
                    mode_next  = cts_pkg::M_STRING;
                end
                else if (c.data == cts_pkg::CH_HASH)
                begin
                    ts_next   = npos;
                    mode_next = cts_pkg::M_HASH;
                end
                else if (c.data == cts_pkg::CH_AT)
                begin
                    ts_next   = npos;
                    mode_next = cts_pkg::M_AT;
                end
                else if (num_wait)
                    r = cts_pkg::RES_WAIT;
                else if (num_yes)
                begin
                    ts_next   = pos_reg;
                    mode_next = (c.data == cts_pkg::CH_DOT) ? cts_pkg::M_FRAC :
                                                              cts_pkg::M_INT;
                end
                else if (c.name_start)
                begin
                    ts_next   = pos_reg;
                    mode_next = cts_pkg::M_IDENT;
                end
                else
                begin
                    em      = 1'b1;
                    e_kind  = c.kind;
                    e_start = pos_reg;
                    e_len   = OB'(1);
                    e_del   = c.data;
                end
            end
        endcase

        // numeric suffix: percent, unit or plain number
        if (do_suffix)
        begin
            nl_next = span;
            if (c.data == cts_pkg::CH_PCT)
            begin
                em        = 1'b1;
                e_kind    = cts_pkg::K_PERCENT;
                e_len     = pspan;
                e_nl      = span;
                mode_next = cts_pkg::M_IDLE;
            end
            else if (c.name_start)
                mode_next = cts_pkg::M_UNIT;
            else
            begin
                em        = 1'b1;
                e_kind    = cts_pkg::K_NUMBER;
                e_nl      = span;
                mode_next = cts_pkg::M_IDLE;
                r         = cts_pkg::RES_AGAIN;
            end
        end
    end

    // token left open at end of source
    always_comb
    begin
        fl_em   = 1'b1;
        fl_kind = cts_pkg::K_WS;
        fl_nl   = '0;
        unique case (mode_reg)
            cts_pkg::M_WS, cts_pkg::M_COPEN, cts_pkg::M_COMMENT, cts_pkg::M_CSTAR:
                fl_kind = cts_pkg::K_WS;
            cts_pkg::M_STRING: fl_kind = cts_pkg::K_STRING;
            cts_pkg::M_HASH:   fl_kind = cts_pkg::K_HASH;
            cts_pkg::M_AT:     fl_kind = cts_pkg::K_AT;
            cts_pkg::M_IDENT:  fl_kind = cts_pkg::K_IDENT;
            cts_pkg::M_INT, cts_pkg::M_FRAC, cts_pkg::M_ESIGN, cts_pkg::M_EXP:
            begin
                fl_kind = cts_pkg::K_NUMBER;
                fl_nl   = span;
            end
            cts_pkg::M_UNIT:
            begin
                fl_kind = cts_pkg::K_DIM;
                fl_nl   = nl_reg;
            end
            default: fl_em = 1'b0;
        endcase
    end

    assign step_go  = (phase_reg == cts_pkg::PH_RUN) && win_ok && (!em || out_free);
    assign wn_next  = (r == cts_pkg::RES_TAKE) ? wn_eff - 2'd1 : wn_eff;
    assign done     = (r == cts_pkg::RES_WAIT) || (wn_next == 2'd0);
    assign flush_go = !fl_em || out_free;
    assign q_pop    = step_go && need_reg;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            cts_pkg::PH_RUN:
            begin
                if (step_go && done && at_end)
                    phase_next = cts_pkg::PH_FLUSH;
            end
            cts_pkg::PH_FLUSH:
            begin
                if (flush_go)
                    phase_next = cts_pkg::PH_EOF;
            end
            cts_pkg::PH_EOF:
            begin
                if (out_free)
                    phase_next = cts_pkg::PH_RUN;
            end
            default: phase_next = cts_pkg::PH_RUN;
        endcase
    end

    // result selection per phase
    always_comb
    begin
        load     = 1'b0;
        ld_kind  = e_kind;
        ld_start = e_start;
        ld_len   = e_len;
        ld_nl    = e_nl;
        ld_del   = e_del;
        ld_last  = 1'b0;
        unique case (phase_reg)
            cts_pkg::PH_RUN:
                load = step_go && em;
            cts_pkg::PH_FLUSH:
            begin
                load     = fl_em && out_free;
                ld_kind  = fl_kind;
                ld_start = ts_reg;
                ld_len   = span;
                ld_nl    = fl_nl;
                ld_del   = 8'd0;
            end
            cts_pkg::PH_EOF:
            begin
                load     = out_free;
                ld_kind  = cts_pkg::K_EOF;
                ld_start = '0;
                ld_len   = '0;
                ld_nl    = '0;
                ld_del   = 8'd0;
                ld_last  = 1'b1;
            end
            default: load = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            token_kind    <= ld_kind;
            text_start    <= sat16(ld_start);
            text_length   <= sat16(ld_len);
            number_length <= sat16(ld_nl);
            delim_byte    <= ld_del;
            last_token    <= ld_last;
        end
        if (step_go)
        begin
            if (r == cts_pkg::RES_TAKE)
            begin
                la_reg[0] <= w[1];
                la_reg[1] <= w[2];
                la_reg[2] <= w[2];
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                    la_reg[i] <= w[i];
            end
            ts_reg    <= ts_next;
            nl_reg    <= nl_next;
            quote_reg <= quote_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= cts_pkg::PH_RUN;
            mode_reg      <= cts_pkg::M_IDLE;
            pos_reg       <= '0;
            esc_reg       <= 1'b0;
            wn_reg        <= 2'd0;
            need_reg      <= 1'b1;
            end_reg       <= 1'b0;
        end
        else
        begin
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            phase_reg <= phase_next;
            if (step_go)
            begin
                mode_reg <= mode_next;
                esc_reg  <= esc_next;
                if (r == cts_pkg::RES_TAKE)
                    pos_reg <= npos;
                wn_reg   <= wn_next;
                need_reg <= done;
                end_reg  <= at_end;
            end
            if (phase_reg == cts_pkg::PH_EOF && out_free)
            begin
                // back to the start of a new stream
                mode_reg <= cts_pkg::M_IDLE;
                pos_reg  <= '0;
                esc_reg  <= 1'b0;
                wn_reg   <= 2'd0;
                need_reg <= 1'b1;
                end_reg  <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: sv/cts_checker.sv
`include "css_token_scanner_assert.svh"

module cts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  src_byte,
    input logic        end_of_source,
    input logic        out_valid,
    input logic        out_stall,
    input logic [4:0]  token_kind,
    input logic [15:0] text_start,
    input logic [15:0] text_length,
    input logic [15:0] number_length,
    input logic [7:0]  delim_byte,
    input logic        last_token
);

    `CTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(token_kind) && $stable(text_start), "stalled token changed")

    `CTS_ASSERT_ALWAYS(a_eof_clean, !(out_valid && last_token) || (token_kind == cts_pkg::K_EOF && text_start == 16'd0 && text_length == 16'd0 && delim_byte == 8'd0), "bad EOF token")

    `CTS_ASSERT_ALWAYS(a_numlen, !out_valid || token_kind == cts_pkg::K_NUMBER || token_kind == cts_pkg::K_PERCENT || token_kind == cts_pkg::K_DIM || number_length == 16'd0, "numeric length on non-number")

    `CTS_ASSERT_ALWAYS(a_delim_len, !(out_valid && delim_byte != 8'd0) || text_length == 16'd1, "single byte token length")

endmodule

bind css_token_scanner cts_checker u_cts_checker (.*);

FILE: sim/css_token_checker.sv
`timescale 1ns / 100ps

module css_token_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  src_byte,
    input  logic        end_of_source,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [4:0]  token_kind,
    input  logic [15:0] text_start,
    input  logic [15:0] text_length,
    input  logic [15:0] number_length,
    input  logic [7:0]  delim_byte,
    input  logic        last_token,
    output int          fail_count,
    output int          pending_tokens,
    output int          tokens_seen
);

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] nlen;
        logic [7:0]  delim;
        logic        last;
    } token_t;

    token_t token_q[$];

    // scanner copy
    int unsigned     pos, tok_start, num_len;
    cts_pkg::mode_t  mode;
    logic [7:0]      quote;
    logic            esc;
    logic [7:0]      look_buf[2];
    int              look_n;
    logic [7:0]      win[3];
    int              wn;
    logic            at_end;

    localparam int unsigned POS_LIMIT = 65535;

    function automatic logic [15:0] sat(int unsigned v);
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic int unsigned nxt();
        return (pos < POS_LIMIT) ? pos + 1 : pos;
    endfunction

    function automatic int unsigned span();
        return (pos >= tok_start) ? pos - tok_start : 0;
    endfunction

    function automatic bit is_dig(int c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_sp(int c);
        return c == 32 || c == 9 || c == 13 || c == 10 || c == 12;
    endfunction

    function automatic bit nm_start(int c);
        return c >= 0 && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
            || c == "_" || c == "-" || c >= 128);
    endfunction

    function automatic bit nm_in(int c);
        return nm_start(c) || is_dig(c);
    endfunction

    // -1 absent at end, -2 unknown yet
    function automatic int peek(int i);
        if (i < wn)
            return win[i];
        return at_end ? -1 : -2;
    endfunction

    task automatic push_token(logic [4:0] k, int unsigned s, int unsigned l,
                              int unsigned n, logic [7:0] d, logic lst);
        token_t t;
        t.kind = k; t.start = sat(s); t.len = sat(l); t.nlen = sat(n);
        t.delim = d; t.last = lst;
        token_q.push_back(t);
    endtask

    function automatic int number_starts(int c);
        int a, b;
        if (is_dig(c))
            return 1;
        if (c == ".")
        begin
            a = peek(1);
            if (a == -2) return -1;
            return is_dig(a);
        end
        if (c == "+" || c == "-")
        begin
            a = peek(1);
            if (a == -2) return -1;
            if (is_dig(a)) return 1;
            if (a == ".")
            begin
                b = peek(2);
                if (b == -2) return -1;
                return is_dig(b);
            end
        end
        return 0;
    endfunction

    function automatic int exponent_ok();
        int a, b;
        a = peek(1);
        if (a == -2) return -1;
        if (is_dig(a)) return 1;
        if (a == "+" || a == "-")
        begin
            b = peek(2);
            if (b == -2) return -1;
            return is_dig(b);
        end
        return 0;
    endfunction

    task automatic close_number(int c, output cts_pkg::res_t r);
        int unsigned e;
        num_len = span();
        if (c == cts_pkg::CH_PCT)
        begin
            e = nxt();
            push_token(cts_pkg::K_PERCENT, tok_start,
                       (e >= tok_start) ? e - tok_start : 0, num_len, 8'd0, 1'b0);
            mode = cts_pkg::M_IDLE;
            r = cts_pkg::RES_TAKE;
        end
        else if (nm_start(c))
        begin
            mode = cts_pkg::M_UNIT;
            r = cts_pkg::RES_TAKE;
        end
        else
        begin
            push_token(cts_pkg::K_NUMBER, tok_start, num_len, num_len, 8'd0, 1'b0);
            mode = cts_pkg::M_IDLE;
            r = cts_pkg::RES_AGAIN;
        end
    endtask

    task automatic scan_idle(int c, output cts_pkg::res_t r);
        int n, a;
        r = cts_pkg::RES_TAKE;
        if (is_sp(c))
        begin
            tok_start = pos; mode = cts_pkg::M_WS;
        end
        else if (c == cts_pkg::CH_SLASH)
        begin
            a = peek(1);
            if (a == -2) r = cts_pkg::RES_WAIT;
            else if (a == cts_pkg::CH_STAR)
            begin
                tok_start = pos; mode = cts_pkg::M_COPEN;
            end
            else push_token(cts_pkg::K_DELIM, pos, 1, 0, 8'(c), 1'b0);
        end
        else if (c == cts_pkg::CH_DQUOTE || c == cts_pkg::CH_SQUOTE)
        begin
            quote = 8'(c); esc = 0; tok_start = nxt(); mode = cts_pkg::M_STRING;
        end
        else if (c == cts_pkg::CH_HASH)
        begin
            tok_start = nxt(); mode = cts_pkg::M_HASH;
        end
        else if (c == cts_pkg::CH_AT)
        begin
            tok_start = nxt(); mode = cts_pkg::M_AT;
        end
        else
        begin
            n = number_starts(c);
            if (n < 0) r = cts_pkg::RES_WAIT;
            else if (n == 1)
            begin
                tok_start = pos;
                mode = (c == cts_pkg::CH_DOT) ? cts_pkg::M_FRAC : cts_pkg::M_INT;
            end
            else if (nm_start(c))
            begin
                tok_start = pos; mode = cts_pkg::M_IDENT;
            end
            else
                push_token(cts_pkg::punct_kind(8'(c)), pos, 1, 0, 8'(c), 1'b0);
        end
    endtask

    task automatic scan_one(output cts_pkg::res_t r);
        int c, e, a;
        c = win[0];
        r = cts_pkg::RES_TAKE;
        case (mode)
            cts_pkg::M_WS:
            begin
                if (!is_sp(c))
                begin
                    a = (c == cts_pkg::CH_SLASH) ? peek(1) : 0;
                    if (a == -2) r = cts_pkg::RES_WAIT;
                    else if (c == cts_pkg::CH_SLASH && a == cts_pkg::CH_STAR)
                        mode = cts_pkg::M_COPEN;
                    else
                    begin
                        push_token(cts_pkg::K_WS, tok_start, span(), 0, 8'd0, 1'b0);
                        mode = cts_pkg::M_IDLE;
                        r = cts_pkg::RES_AGAIN;
                    end
                end
            end
            cts_pkg::M_COPEN: mode = cts_pkg::M_COMMENT;
            cts_pkg::M_COMMENT: if (c == cts_pkg::CH_STAR) mode = cts_pkg::M_CSTAR;
            cts_pkg::M_CSTAR:
            begin
                if (c == cts_pkg::CH_SLASH) mode = cts_pkg::M_WS;
                else if (c != cts_pkg::CH_STAR) mode = cts_pkg::M_COMMENT;
            end
            cts_pkg::M_STRING:
            begin
                if (esc) esc = 0;
                else if (c == cts_pkg::CH_BSLASH) esc = 1;
                else if (c == quote)
                begin
                    push_token(cts_pkg::K_STRING, tok_start, span(), 0, 8'd0, 1'b0);
                    mode = cts_pkg::M_IDLE;
                end
            end
            cts_pkg::M_HASH, cts_pkg::M_AT, cts_pkg::M_IDENT:
            begin
                if (!nm_in(c))
                begin
                    if (mode == cts_pkg::M_IDENT && c == cts_pkg::CH_LPAREN)
                        push_token(cts_pkg::K_FUNC, tok_start, span(), 0, 8'd0, 1'b0);
                    else
                    begin
                        push_token(mode == cts_pkg::M_HASH ? cts_pkg::K_HASH :
                                   mode == cts_pkg::M_AT ? cts_pkg::K_AT : cts_pkg::K_IDENT,
                                   tok_start, span(), 0, 8'd0, 1'b0);
                        r = cts_pkg::RES_AGAIN;
                    end
                    mode = cts_pkg::M_IDLE;
                end
            end
            cts_pkg::M_INT, cts_pkg::M_FRAC:
            begin
                if (is_dig(c)) r = cts_pkg::RES_TAKE;
                else if (mode == cts_pkg::M_INT && c == cts_pkg::CH_DOT)
                    mode = cts_pkg::M_FRAC;
                else
                begin
                    e = (c == cts_pkg::CH_LO_E || c == cts_pkg::CH_UP_E) ? exponent_ok() : 0;
                    if (e < 0) r = cts_pkg::RES_WAIT;
                    else if (e == 1) mode = cts_pkg::M_ESIGN;
                    else close_number(c, r);
                end
            end
            cts_pkg::M_ESIGN:
            begin
                mode = cts_pkg::M_EXP;
                if (!(c == cts_pkg::CH_PLUS || c == cts_pkg::CH_MINUS))
                    r = cts_pkg::RES_AGAIN;
            end
            cts_pkg::M_EXP: if (!is_dig(c)) close_number(c, r);
            cts_pkg::M_UNIT:
            begin
                if (!nm_in(c))
                begin
                    push_token(cts_pkg::K_DIM, tok_start, span(), num_len, 8'd0, 1'b0);
                    mode = cts_pkg::M_IDLE;
                    r = cts_pkg::RES_AGAIN;
                end
            end
            default:
            begin
                mode = cts_pkg::M_IDLE;
                scan_idle(c, r);
            end
        endcase
    endtask

    task automatic scanner_clear();
        pos = 0; mode = cts_pkg::M_IDLE; tok_start = 0; num_len = 0;
        quote = 0; esc = 0; look_n = 0;
    endtask

    task automatic predict_request(logic [7:0] b, logic eos);
        cts_pkg::res_t r;
        at_end = eos;
        wn = look_n;
        for (int i = 0; i < wn; i++) win[i] = look_buf[i];
        win[wn++] = b;
        while (wn > 0)
        begin
            scan_one(r);
            if (r == cts_pkg::RES_WAIT) break;
            if (r == cts_pkg::RES_TAKE)
            begin
                for (int i = 1; i < wn; i++) win[i-1] = win[i];
                wn--;
                pos = nxt();
            end
        end
        if (wn > 2) wn = 2;
        for (int i = 0; i < wn; i++) look_buf[i] = win[i];
        look_n = wn;
        if (eos)
        begin
            case (mode)
                cts_pkg::M_WS, cts_pkg::M_COPEN, cts_pkg::M_COMMENT, cts_pkg::M_CSTAR:
                    push_token(cts_pkg::K_WS, tok_start, span(), 0, 8'd0, 1'b0);
                cts_pkg::M_STRING:
                    push_token(cts_pkg::K_STRING, tok_start, span(), 0, 8'd0, 1'b0);
                cts_pkg::M_HASH:
                    push_token(cts_pkg::K_HASH, tok_start, span(), 0, 8'd0, 1'b0);
                cts_pkg::M_AT:
                    push_token(cts_pkg::K_AT, tok_start, span(), 0, 8'd0, 1'b0);
                cts_pkg::M_IDENT:
                    push_token(cts_pkg::K_IDENT, tok_start, span(), 0, 8'd0, 1'b0);
                cts_pkg::M_INT, cts_pkg::M_FRAC, cts_pkg::M_ESIGN, cts_pkg::M_EXP:
                    push_token(cts_pkg::K_NUMBER, tok_start, span(), span(), 8'd0, 1'b0);
                cts_pkg::M_UNIT:
                    push_token(cts_pkg::K_DIM, tok_start, span(), num_len, 8'd0, 1'b0);
                default: ;
            endcase
            push_token(cts_pkg::K_EOF, 0, 0, 0, 8'd0, 1'b1);
            scanner_clear();
        end
    endtask

    task automatic report(string what, int got, int want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        token_t t;
        if (!rst_n)
        begin
            fail_count = 0;
            tokens_seen = 0;
            token_q.delete();
            scanner_clear();
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_request(src_byte, end_of_source);
            if (out_valid && !out_stall)
            begin
                tokens_seen++;
                if (token_q.size() == 0)
                    report("unexpected token kind", token_kind, -1);
                else
                begin
                    t = token_q.pop_front();
                    if (token_kind !== t.kind) report("kind", token_kind, t.kind);
                    if (text_start !== t.start) report("text_start", text_start, t.start);
                    if (text_length !== t.len) report("text_length", text_length, t.len);
                    if (number_length !== t.nlen)
                        report("number_length", number_length, t.nlen);
                    if (delim_byte !== t.delim) report("delim_byte", delim_byte, t.delim);
                    if (last_token !== t.last) report("last_token", last_token, t.last);
                end
            end
        end
        pending_tokens = token_q.size();
    end

endmodule

FILE: sim/css_token_scanner_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the CSS token scanner. The checker beside the
// block predicts every token from the accepted source bytes.
module css_token_scanner_tb;

    localparam int RANDOM_ITEMS = 360;
    localparam int IDLE_LIMIT   = 2000;   // cycles without any handshake

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [7:0]  src_byte = 0;
    logic        end_of_source = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [4:0]  token_kind;
    logic [15:0] text_start, text_length, number_length;
    logic [7:0]  delim_byte;
    logic        last_token;
    int          fail_count, pending_tokens, tokens_seen;
    int          requests_sent = 0;
    int          idle_cycles = 0;
    int          stall_mode = 0;

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    css_token_scanner dut (.*);

    css_token_checker chk (.*);

    // receiver: stall pattern changes at random; some stretches never stall
    always @(posedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // watchdog: count cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired");
            $display("simulation failed");
            $finish;
        end
    end

    int gap_left = 0;
    int burst_left = 0;

    // send one request; valid stays high between back-to-back requests
    task automatic send_byte(logic [7:0] b, logic eos);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
        if (gap_left > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_left) @(posedge clk);
            gap_left = 0;
        end
        in_valid <= 1'b1;
        src_byte <= b;
        end_of_source <= eos;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        requests_sent++;
    endtask

    task automatic send_text(string s, logic close);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], close && (i == s.len() - 1));
    endtask

    // random fragment of CSS-like text, biased toward well-formed tokens
    function automatic string css_fragment();
        string pool[] = '{" ", "\t\n", "/* c */", "/**/", "/* *x**/", "\"s\\\"q\"",
            "'a'", "#id", "#", "@media", "@", "12", "1.", ".5", "-3.2e+4", "1e",
            "2em", "50%", "3E-x", "+.7", "-.", "+", "url(", "ab-c_9", "-x",
            ":", ";", ",", "{", "}", "(", ")", "[", "]", "!", ".", ">", "~",
            "*", "/", "$", "\x80\xff", "1.5e3px", "4e+"};
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    initial
    begin
        string s;
        int    sent_random;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: comments, strings, escapes, numbers, names, punctuation
        send_text(" /* a */ \"x\\\"y\" 'q' #h # @k @", 0);
        send_text(" 1. 2e 3e+5 4e-q 50% 6px .5 +1 -.2 -x fn( :;,{}()[]!.>+~*$", 0);
        send_text("/x\x00\xff", 1);
        // unterminated comment and string, each as its own stream
        send_text("a/* open", 1);
        send_text("\"open", 1);
        send_byte(8'h2F, 1);

        // full drain before going on
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_tokens != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        sent_random = 0;
        while (sent_random < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) == 0)
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 30) == 0);
            else
            begin
                s = css_fragment();
                send_text(s, $urandom_range(0, 25) == 0);
                sent_random += s.len() - 1;
            end
            sent_random++;
        end
        send_byte(8'h20, 1);
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending_tokens != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("sent %0d source bytes, checked %0d tokens", requests_sent, tokens_seen);
        if (fail_count == 0 && pending_tokens == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/cts_pkg.sv
sv/cts_front.sv
sv/cts_fifo.sv
sv/cts_back.sv
sv/css_token_scanner.sv
sv/cts_checker.sv
sim/css_token_checker.sv
sim/css_token_scanner_tb.sv
